// ----- hdl/dbsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dbsm_pkg
// shared types, constants and helpers for the debug breakpoint slot merger
// ----------------------------------------------------------------------------
`default_nettype none

package dbsm_pkg;

    // slot geometry
    localparam int unsigned SLOT_NUM   = 4;
    localparam int unsigned SLOT_IDX_W = $clog2(SLOT_NUM);
    localparam int unsigned SLOT_W     = 64;
    localparam int unsigned ADDR_W     = 59;
    localparam int unsigned COND_W     = 4;
    localparam int unsigned COND_LSB   = ADDR_W;
    localparam int unsigned EN_BIT     = SLOT_W - 1;
    localparam int unsigned EXT_W      = SLOT_W - ADDR_W;

    // guest control word layout
    localparam int unsigned CTL_W        = 32;
    localparam int unsigned CTL_COND_LSB = 16;
    localparam logic [15:0] CTL_LOW_MASK = 16'hFFFF;
    localparam int unsigned TRACE_LSB    = 8;
    localparam int unsigned TRACE_W      = 2;

    // configuration register map
    localparam int unsigned CFG_IDX_W         = 4;
    localparam int unsigned CFG_WANTED_BASE   = 0;
    localparam int unsigned CFG_IGNORED_BASE  = 4;
    localparam int unsigned CFG_REG_NUM       = 8;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef t_slot [SLOT_NUM-1:0] t_slot_vec;

    typedef struct packed {
        t_slot_vec wanted;
        t_slot_vec ignored;
    } t_slot_set;

    // address masked to 59 bits, condition nibble and enable on top
    function automatic t_slot pack_guest(input logic [SLOT_W-1:0] addr,
                                         input logic [COND_W-1:0] cond,
                                         input logic en);
        pack_guest = {en, cond, addr[ADDR_W-1:0]};
    endfunction

    function automatic logic [SLOT_W-1:0] sign_ext_addr(input t_slot s);
        sign_ext_addr = {{EXT_W{s[ADDR_W-1]}}, s[ADDR_W-1:0]};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dbsm_cfg.sv -----
// ----------------------------------------------------------------------------
// dbsm_cfg
// wanted and ignored slot registers behind the configuration write channel
// ----------------------------------------------------------------------------
`default_nettype none

module dbsm_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dbsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dbsm_pkg::SLOT_W-1:0]    i_cfg_data,
    output dbsm_pkg::t_slot_set                 o_slots
);

    dbsm_pkg::t_slot_set r_slots;
    dbsm_pkg::t_slot_set n_slots;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_slots = r_slots;
        if (i_cfg_valid) begin
            if (i_cfg_index < dbsm_pkg::CFG_IDX_W'(dbsm_pkg::CFG_IGNORED_BASE)) begin
                n_slots.wanted[i_cfg_index[dbsm_pkg::SLOT_IDX_W-1:0]] = i_cfg_data;
            end else if (i_cfg_index < dbsm_pkg::CFG_IDX_W'(dbsm_pkg::CFG_REG_NUM)) begin
                n_slots.ignored[i_cfg_index[dbsm_pkg::SLOT_IDX_W-1:0]] = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
        end else begin
            r_slots <= n_slots;
        end
    end

    assign o_slots = r_slots;

endmodule

`default_nettype wire

// ----- hdl/debug_breakpoint_slot_merger.sv -----
// ----------------------------------------------------------------------------
// debug_breakpoint_slot_merger
// merges guest hardware breakpoints with configured wanted/ignored slots
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------
//  input    | in        | i_valid / o_ready          | guest addresses, control, flags
//  result   | out       | o_valid / i_ready          | final slots, control, mask, strobes
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  one transfer per cycle on each channel while it is not stalled; input to result passes three registered stages
//  pipeline: suppress/pack -> compact into free slots -> build control word
//  a full pipeline with i_ready low holds every stage; nothing is dropped
//  o_ready falls only when all three stages hold data and the result is stalled
//  synchronous active-low reset clears stage valids and slot registers
//
`default_nettype none

module debug_breakpoint_slot_merger (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input items
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [63:0]                    i_guest_address_0,
    input  wire logic [63:0]                    i_guest_address_1,
    input  wire logic [63:0]                    i_guest_address_2,
    input  wire logic [63:0]                    i_guest_address_3,
    input  wire logic [31:0]                    i_guest_control,
    input  wire logic                           i_kernel_mode,
    input  wire logic                           i_tracing_supported,
    input  wire logic                           i_tracing_busy,
    // result items
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [63:0]                         o_final_address_0,
    output logic [63:0]                         o_final_address_1,
    output logic [63:0]                         o_final_address_2,
    output logic [63:0]                         o_final_address_3,
    output logic [31:0]                         o_final_control,
    output logic [3:0]                          o_occupied_mask,
    output logic                                o_debugctl_write,
    output logic [1:0]                          o_debugctl_value,
    output logic                                o_clear_status,
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dbsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]                    i_cfg_data
);

    localparam int unsigned N = dbsm_pkg::SLOT_NUM;

    dbsm_pkg::t_slot_set slots;

    dbsm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_slots     (slots)
    );

    // stage advance: a stage loads when it is empty or its successor moves
    logic en1, en2, en3;

    logic r_s1_valid, r_s2_valid, r_o_valid;

    assign en3     = !r_o_valid || i_ready;
    assign en2     = !r_s2_valid || en3;
    assign en1     = !r_s1_valid || en2;
    assign o_ready = en1;
    assign o_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_valid <= i_valid;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en3) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: pack guest slots and drop those equal to an ignored slot
    // ------------------------------------------------------------------
    logic [63:0]               guest_addr [N];
    dbsm_pkg::t_slot_vec       n_s1_slot;
    logic                      n_s1_active;
    logic                      n_s1_dbg_wr;
    logic [dbsm_pkg::TRACE_W-1:0] n_s1_dbg_val;
    logic [dbsm_pkg::TRACE_W-1:0] trace_bits;

    assign guest_addr[0] = i_guest_address_0;
    assign guest_addr[1] = i_guest_address_1;
    assign guest_addr[2] = i_guest_address_2;
    assign guest_addr[3] = i_guest_address_3;

    for (genvar gi = 0; gi < N; gi++) begin : g_pack
        dbsm_pkg::t_slot packed_slot;
        logic [N-1:0]    hit;

        assign packed_slot = dbsm_pkg::pack_guest(
            guest_addr[gi],
            i_guest_control[dbsm_pkg::CTL_COND_LSB + dbsm_pkg::COND_W*gi +:
                            dbsm_pkg::COND_W],
            i_guest_control[2*gi]);

        for (genvar gj = 0; gj < N; gj++) begin : g_cmp
            assign hit[gj] = (packed_slot == slots.ignored[gj]);
        end

        // a suppressed slot becomes all zero, which also makes it free
        assign n_s1_slot[gi] = (|hit) ? '0 : packed_slot;
    end

    assign trace_bits  = i_guest_control[dbsm_pkg::TRACE_LSB +: dbsm_pkg::TRACE_W];
    assign n_s1_active = |(i_guest_control[15:0] & dbsm_pkg::CTL_LOW_MASK);

    // debugctl only touched in user context when tracing is free to use
    always_comb begin
        n_s1_dbg_wr  = n_s1_active && !i_kernel_mode && (|trace_bits)
                       && i_tracing_supported && !i_tracing_busy;
        n_s1_dbg_val = n_s1_dbg_wr ? trace_bits : '0;
    end

    dbsm_pkg::t_slot_vec          r_s1_slot;
    logic                         r_s1_active;
    logic                         r_s1_dbg_wr;
    logic [dbsm_pkg::TRACE_W-1:0] r_s1_dbg_val;
    logic                         r_s1_clr;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_slot    <= n_s1_slot;
            r_s1_active  <= n_s1_active;
            r_s1_dbg_wr  <= n_s1_dbg_wr;
            r_s1_dbg_val <= n_s1_dbg_val;
            r_s1_clr     <= !i_kernel_mode;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: wanted slots replace all slots if inactive, else fill free guest slots in order
    // ------------------------------------------------------------------
    logic [N-1:0]                    free;
    logic [dbsm_pkg::SLOT_IDX_W-1:0] rank [N];
    dbsm_pkg::t_slot_vec             n_s2_slot;
    logic [N-1:0]                    n_s2_mask;

    for (genvar gi = 0; gi < N; gi++) begin : g_free
        assign free[gi] = !r_s1_slot[gi][dbsm_pkg::EN_BIT];
    end

    // rank of a slot = number of free slots below it
    always_comb begin
        rank[0] = '0;
        rank[1] = {1'b0, free[0]};
        rank[2] = rank[1] + {1'b0, free[1]};
        rank[3] = rank[2] + {1'b0, free[2]};
    end

    for (genvar gi = 0; gi < N; gi++) begin : g_fill
        always_comb begin
            if (!r_s1_active) begin
                n_s2_slot[gi] = slots.wanted[gi];
                n_s2_mask[gi] = 1'b0;
            end else if (free[gi]) begin
                n_s2_slot[gi] = slots.wanted[rank[gi]];
                n_s2_mask[gi] = 1'b0;
            end else begin
                n_s2_slot[gi] = r_s1_slot[gi];
                n_s2_mask[gi] = 1'b1;
            end
        end
    end

    dbsm_pkg::t_slot_vec          r_s2_slot;
    logic [N-1:0]                 r_s2_mask;
    logic                         r_s2_dbg_wr;
    logic [dbsm_pkg::TRACE_W-1:0] r_s2_dbg_val;
    logic                         r_s2_clr;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_slot    <= n_s2_slot;
            r_s2_mask    <= n_s2_mask;
            r_s2_dbg_wr  <= r_s1_dbg_wr;
            r_s2_dbg_val <= r_s1_dbg_val;
            r_s2_clr     <= r_s1_clr;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: control word and sign-extended addresses
    // ------------------------------------------------------------------
    logic [dbsm_pkg::CTL_W-1:0] n_ctl;
    logic [63:0]                n_addr [N];

    always_comb begin
        n_ctl = '0;
        for (int k = 0; k < N; k++) begin
            n_ctl[dbsm_pkg::CTL_COND_LSB + dbsm_pkg::COND_W*k +: dbsm_pkg::COND_W] =
                r_s2_slot[k][dbsm_pkg::COND_LSB +: dbsm_pkg::COND_W];
            n_ctl[2*k] = r_s2_slot[k][dbsm_pkg::EN_BIT];
        end
    end

    for (genvar gi = 0; gi < N; gi++) begin : g_ext
        assign n_addr[gi] = dbsm_pkg::sign_ext_addr(r_s2_slot[gi]);
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            o_final_address_0 <= n_addr[0];
            o_final_address_1 <= n_addr[1];
            o_final_address_2 <= n_addr[2];
            o_final_address_3 <= n_addr[3];
            o_final_control   <= n_ctl;
            o_occupied_mask   <= r_s2_mask;
            o_debugctl_write  <= r_s2_dbg_wr;
            o_debugctl_value  <= r_s2_dbg_val;
            o_clear_status    <= r_s2_clr;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dbsm_chk.sv -----
// ----------------------------------------------------------------------------
// dbsm_chk
// port-level checks on the result channel of the slot merger
// ----------------------------------------------------------------------------
`default_nettype none

module dbsm_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_valid,
    input  wire logic        i_ready,
    input  wire logic [63:0] o_final_address_0,
    input  wire logic [31:0] o_final_control,
    input  wire logic        o_debugctl_write,
    input  wire logic [1:0]  o_debugctl_value,
    input  wire logic        o_clear_status
);

    // stalled result stays valid and its control word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_final_control))
        else $error("result changed while stalled");

    // debugctl write only in user context, with nonzero trace bits
    a_dbg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_debugctl_write |-> o_clear_status && (o_debugctl_value != 2'b00))
        else $error("debugctl write without user context or trace bits");

    a_dbg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_debugctl_write |-> o_debugctl_value == 2'b00)
        else $error("debugctl value without write");

    // only local enables and condition nibbles may be set
    a_ctl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_final_control & 32'h0000_FFAA) == 32'h0)
        else $error("stray bits in final control");

    a_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_final_address_0[63:59] == {5{o_final_address_0[58]}})
        else $error("address not sign-extended");

endmodule

bind debug_breakpoint_slot_merger dbsm_chk u_dbsm_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_final_address_0 (o_final_address_0),
    .o_final_control   (o_final_control),
    .o_debugctl_write  (o_debugctl_write),
    .o_debugctl_value  (o_debugctl_value),
    .o_clear_status    (o_clear_status)
);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the debug breakpoint slot merger against its own slot-merge predictor
// under random idle and stall on both channels, several register settings and
// one long result hold-off that backs the pipeline up into the input side
// ----------------------------------------------------------------------------

module testbench;

    // one guest context switch event as it appears on the input ports
    typedef struct packed {
        dbsm_pkg::t_slot_vec          addr;
        logic [dbsm_pkg::CTL_W-1:0]   ctl;
        logic                         kernel;
        logic                         trace_sup;
        logic                         trace_busy;
    } t_context;

    // one merged result as it appears on the output ports
    typedef struct packed {
        dbsm_pkg::t_slot_vec          addr;
        logic [dbsm_pkg::CTL_W-1:0]   ctl;
        logic [3:0]                   occupied;
        logic                         dbg_wr;
        logic [1:0]                   dbg_val;
        logic                         clr_status;
    } t_merge_result;

    // predicts every merge and holds the merges still owed by the block
    class merge_predictor;
        dbsm_pkg::t_slot_vec  wanted;
        dbsm_pkg::t_slot_vec  ignored;
        t_merge_result        pending_merges[$];
        int                   mismatch_count;

        function new();
            wanted = '0;
            ignored = '0;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [dbsm_pkg::CFG_IDX_W-1:0] idx,
                                dbsm_pkg::t_slot value);
            if (idx < dbsm_pkg::CFG_IGNORED_BASE)
                wanted[idx - dbsm_pkg::CFG_WANTED_BASE] = value;
            else if (idx < dbsm_pkg::CFG_REG_NUM)
                ignored[idx - dbsm_pkg::CFG_IGNORED_BASE] = value;
        endfunction

        function t_merge_result merge_slots(t_context c);
            dbsm_pkg::t_slot_vec  slot;
            dbsm_pkg::t_slot      g;
            t_merge_result        r;
            int                   free_idx;
            bit                   hit;
            slot = wanted;
            r = '0;
            free_idx = 0;
            // a guest control word with an empty low half leaves the wanted slots as they are
            if ((c.ctl[15:0] & dbsm_pkg::CTL_LOW_MASK) != 0) begin
                if (!c.kernel && c.ctl[dbsm_pkg::TRACE_LSB +: dbsm_pkg::TRACE_W] != 0
                        && c.trace_sup && !c.trace_busy) begin
                    r.dbg_wr = 1'b1;
                    r.dbg_val = c.ctl[dbsm_pkg::TRACE_LSB +: dbsm_pkg::TRACE_W];
                end
                for (int i = 0; i < dbsm_pkg::SLOT_NUM; i++) begin
                    g = {c.ctl[2*i],
                         c.ctl[dbsm_pkg::CTL_COND_LSB + dbsm_pkg::COND_W*i +:
                               dbsm_pkg::COND_W],
                         c.addr[i][dbsm_pkg::ADDR_W-1:0]};
                    hit = 0;
                    for (int j = 0; j < dbsm_pkg::SLOT_NUM; j++)
                        if (g == ignored[j])
                            hit = 1;
                    if (hit)
                        g = '0;
                    // only the enable bit decides whether a slot is taken
                    if (g[dbsm_pkg::EN_BIT]) begin
                        r.occupied[i] = 1'b1;
                        slot[i] = g;
                    end else begin
                        slot[i] = wanted[free_idx];
                        free_idx++;
                    end
                end
            end
            for (int i = 0; i < dbsm_pkg::SLOT_NUM; i++) begin
                r.ctl[dbsm_pkg::CTL_COND_LSB + dbsm_pkg::COND_W*i +: dbsm_pkg::COND_W] =
                    slot[i][dbsm_pkg::COND_LSB +: dbsm_pkg::COND_W];
                r.ctl[2*i] = slot[i][dbsm_pkg::EN_BIT];
                r.addr[i] = {{dbsm_pkg::EXT_W{slot[i][dbsm_pkg::ADDR_W-1]}},
                             slot[i][dbsm_pkg::ADDR_W-1:0]};
            end
            r.clr_status = !c.kernel;
            return r;
        endfunction

        function void note_context(t_context c);
            pending_merges.push_back(merge_slots(c));
        endfunction

        function int pending();
            return pending_merges.size();
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %0s: got %h, expected %h", what, got, want);
            mismatch_count++;
        endtask

        task check_merge(t_merge_result got);
            t_merge_result want;
            if (pending_merges.size() == 0) begin
                report_mismatch("result transfer with nothing pending", 0, 0);
            end else begin
                want = pending_merges.pop_front();
                for (int i = 0; i < dbsm_pkg::SLOT_NUM; i++)
                    if (got.addr[i] !== want.addr[i])
                        report_mismatch($sformatf("final_address_%0d", i),
                                        got.addr[i], want.addr[i]);
                if (got.ctl !== want.ctl)
                    report_mismatch("final_control", got.ctl, want.ctl);
                if (got.occupied !== want.occupied)
                    report_mismatch("occupied_mask", got.occupied, want.occupied);
                if (got.dbg_wr !== want.dbg_wr)
                    report_mismatch("debugctl_write", got.dbg_wr, want.dbg_wr);
                if (got.dbg_val !== want.dbg_val)
                    report_mismatch("debugctl_value", got.dbg_val, want.dbg_val);
                if (got.clr_status !== want.clr_status)
                    report_mismatch("clear_status", got.clr_status, want.clr_status);
            end
        endtask
    endclass

    localparam int HOLD_CYCLES  = 150;  // long result hold-off
    localparam int DRAIN_CYCLES = 8;    // longer than the three-stage pipeline takes to empty
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 80;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic [63:0]                      i_guest_address_0;
    logic [63:0]                      i_guest_address_1;
    logic [63:0]                      i_guest_address_2;
    logic [63:0]                      i_guest_address_3;
    logic [31:0]                      i_guest_control;
    logic                             i_kernel_mode;
    logic                             i_tracing_supported;
    logic                             i_tracing_busy;
    logic                             o_valid;
    logic                             i_ready;
    logic [63:0]                      o_final_address_0;
    logic [63:0]                      o_final_address_1;
    logic [63:0]                      o_final_address_2;
    logic [63:0]                      o_final_address_3;
    logic [31:0]                      o_final_control;
    logic [3:0]                       o_occupied_mask;
    logic                             o_debugctl_write;
    logic [1:0]                       o_debugctl_value;
    logic                             o_clear_status;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [dbsm_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [63:0]                      i_cfg_data;

    merge_predictor        sb;
    dbsm_pkg::t_slot_set   cur_set;            // registers as last loaded, for shaping stimulus
    int                    send_gap_pct  = 0;  // chance of an idle gap before a sent item
    int                    ready_stall_pct = 0; // chance of a stall on the result side
    bit                    hold_req = 0;       // asks the receiver for one long hold-off

    debug_breakpoint_slot_merger dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_guest_address_0   (i_guest_address_0),
        .i_guest_address_1   (i_guest_address_1),
        .i_guest_address_2   (i_guest_address_2),
        .i_guest_address_3   (i_guest_address_3),
        .i_guest_control     (i_guest_control),
        .i_kernel_mode       (i_kernel_mode),
        .i_tracing_supported (i_tracing_supported),
        .i_tracing_busy      (i_tracing_busy),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_final_address_0   (o_final_address_0),
        .o_final_address_1   (o_final_address_1),
        .o_final_address_2   (o_final_address_2),
        .o_final_address_3   (o_final_address_3),
        .o_final_control     (o_final_control),
        .o_occupied_mask     (o_occupied_mask),
        .o_debugctl_write    (o_debugctl_write),
        .o_debugctl_value    (o_debugctl_value),
        .o_clear_status      (o_clear_status),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 30);
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------------
    // monitor: all transfers are seen here at the clock edge, so the
    // prediction for an item is queued before its result can ever show up
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_context       c;
        t_merge_result  got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_valid && o_ready) begin
                c.addr = {i_guest_address_3, i_guest_address_2,
                          i_guest_address_1, i_guest_address_0};
                c.ctl = i_guest_control;
                c.kernel = i_kernel_mode;
                c.trace_sup = i_tracing_supported;
                c.trace_busy = i_tracing_busy;
                sb.note_context(c);
            end
            if (o_valid && i_ready) begin
                got.addr = {o_final_address_3, o_final_address_2,
                            o_final_address_1, o_final_address_0};
                got.ctl = o_final_control;
                got.occupied = o_occupied_mask;
                got.dbg_wr = o_debugctl_write;
                got.dbg_val = o_debugctl_value;
                got.clr_status = o_clear_status;
                sb.check_merge(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request so the
    // pipeline fills and o_ready has to drop
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0) begin
                stall_left = pick_gap(ready_stall_pct);
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    // one item on the input channel; valid stays up between back-to-back items
    task send_context(t_context c);
        int gap;
        gap = pick_gap(send_gap_pct);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_guest_address_0 <= c.addr[0];
        i_guest_address_1 <= c.addr[1];
        i_guest_address_2 <= c.addr[2];
        i_guest_address_3 <= c.addr[3];
        i_guest_control <= c.ctl;
        i_kernel_mode <= c.kernel;
        i_tracing_supported <= c.trace_sup;
        i_tracing_busy <= c.trace_busy;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // writes all eight registers back to back; only called with the block idle
    task load_setting(dbsm_pkg::t_slot_set s);
        for (int r = 0; r < dbsm_pkg::CFG_REG_NUM; r++) begin
            i_cfg_valid <= 1'b1;
            if (r < dbsm_pkg::SLOT_NUM) begin
                i_cfg_index <= dbsm_pkg::CFG_IDX_W'(dbsm_pkg::CFG_WANTED_BASE + r);
                i_cfg_data <= s.wanted[r];
            end else begin
                i_cfg_index <= dbsm_pkg::CFG_IDX_W'(dbsm_pkg::CFG_IGNORED_BASE + r
                                                    - dbsm_pkg::SLOT_NUM);
                i_cfg_data <= s.ignored[r - dbsm_pkg::SLOT_NUM];
            end
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cur_set = s;
    endtask

    // drop valid, wait for every owed result, then let the pipeline settle
    task wait_drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_context make_ctx(logic [63:0] a0, logic [63:0] a1,
                                          logic [63:0] a2, logic [63:0] a3,
                                          logic [31:0] ctl, logic km,
                                          logic sup, logic busy);
        t_context c;
        c.addr = {a3, a2, a1, a0};
        c.ctl = ctl;
        c.kernel = km;
        c.trace_sup = sup;
        c.trace_busy = busy;
        return c;
    endfunction

    function automatic dbsm_pkg::t_slot rand_slot();
        dbsm_pkg::t_slot s;
        s = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: s = '0;
            1: s = '1;
            2: s[dbsm_pkg::EN_BIT] = 1'b1;
            3: s[dbsm_pkg::EN_BIT] = 1'b0;
            default: ;
        endcase
        return s;
    endfunction

    // random context; about a third of the slots copy an ignored entry so
    // that suppression happens often, with random bits above the address
    function automatic t_context rand_context();
        t_context                       c;
        logic [dbsm_pkg::EXT_W-1:0]     hi;
        int                             j;
        for (int i = 0; i < dbsm_pkg::SLOT_NUM; i++) begin
            c.addr[i] = {$urandom, $urandom};
            case ($urandom_range(0, 11))
                0: c.addr[i] = '0;
                1: c.addr[i] = '1;
                2: c.addr[i] = 64'd1 << (dbsm_pkg::ADDR_W - 1);
                default: ;
            endcase
        end
        c.ctl = $urandom;
        if ($urandom_range(0, 7) == 0)
            c.ctl[15:0] = '0;
        for (int i = 0; i < dbsm_pkg::SLOT_NUM; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                j = $urandom_range(0, dbsm_pkg::SLOT_NUM - 1);
                hi = dbsm_pkg::EXT_W'($urandom);
                c.addr[i] = {hi, cur_set.ignored[j][dbsm_pkg::ADDR_W-1:0]};
                c.ctl[dbsm_pkg::CTL_COND_LSB + dbsm_pkg::COND_W*i +: dbsm_pkg::COND_W] =
                    cur_set.ignored[j][dbsm_pkg::COND_LSB +: dbsm_pkg::COND_W];
                c.ctl[2*i] = cur_set.ignored[j][dbsm_pkg::EN_BIT];
            end
        end
        c.kernel = 1'($urandom_range(0, 1));
        c.trace_sup = 1'($urandom_range(0, 1));
        c.trace_busy = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // directed items against a hand-made register setting
    //   wanted 0  enabled, plain address
    //   wanted 1  enable clear but other bits set, still counts as free
    //   wanted 2  enabled, address bit 58 set for sign extension
    //   wanted 3  all ones
    //   ignored 0 enabled guest slot with condition 5
    //   ignored 1 zero, ignored 2 all ones, ignored 3 a disabled guest slot
    // ------------------------------------------------------------------------
    localparam logic [dbsm_pkg::ADDR_W-1:0] IGN_ADDR  = 59'h000_0000_dead_beef;
    localparam logic [dbsm_pkg::ADDR_W-1:0] OFF_ADDR  = 59'h000_0000_0000_1234;
    localparam logic [63:0]                 ALL_ONES  = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0]                 BIT58     = 64'h0400_0000_0000_0000;
    localparam logic [63:0]                 HIGH_ONLY = 64'hf800_0000_0000_0000;

    function automatic dbsm_pkg::t_slot_set directed_setting();
        dbsm_pkg::t_slot_set s;
        s.wanted[0] = {1'b1, 4'ha, 59'h000_0123_4567_89ab};
        s.wanted[1] = {1'b0, 4'h7, 59'h555_5555_5555_5555};
        s.wanted[2] = {1'b1, 4'h3, 59'h400_0000_0000_0010};
        s.wanted[3] = '1;
        s.ignored[0] = {1'b1, 4'h5, IGN_ADDR};
        s.ignored[1] = '0;
        s.ignored[2] = '1;
        s.ignored[3] = {1'b0, 4'h3, OFF_ADDR};
        return s;
    endfunction

    task run_directed();
        // empty low half of the control word: wanted slots pass untouched
        send_context(make_ctx(0, 0, 0, 0, 32'h0, 0, 0, 0));
        send_context(make_ctx(ALL_ONES, ALL_ONES, 0, BIT58, 32'hffff_0000, 0, 1, 0));
        // all-ones guest slots equal an ignored entry and are dropped
        send_context(make_ctx(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 32'hffff_ffff,
                              1, 1, 0));
        send_context(make_ctx(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 32'hffff_ffff,
                              0, 1, 0));
        // tracing bits without enables: every slot free, write decided by flags
        send_context(make_ctx(1, 2, 3, 4, 32'h0000_0100, 0, 1, 0));
        send_context(make_ctx(1, 2, 3, 4, 32'h0000_0200, 0, 1, 1));
        send_context(make_ctx(1, 2, 3, 4, 32'h0000_0300, 0, 0, 0));
        send_context(make_ctx(1, 2, 3, 4, 32'h0000_0300, 1, 1, 0));
        send_context(make_ctx(1, 2, 3, 4, 32'h0000_0300, 0, 1, 0));
        // guest slot 0 matches ignored 0 once its high address bits are masked off
        send_context(make_ctx(HIGH_ONLY | IGN_ADDR, 64'h10, BIT58, 64'h20,
                              32'h0000_0055 | (32'h5 << dbsm_pkg::CTL_COND_LSB),
                              0, 1, 0));
        // high address bits only: masked to zero, but for bit 58 in slot 2
        send_context(make_ctx(HIGH_ONLY, HIGH_ONLY, HIGH_ONLY | BIT58, HIGH_ONLY,
                              32'h9876_0055, 0, 0, 0));
        // enables clear but condition and address bits set: slots still free
        send_context(make_ctx(ALL_ONES, 64'h1, BIT58, 64'h2, 32'hffff_ffaa, 0, 1, 0));
        // only slots 1 and 3 enabled
        send_context(make_ctx(64'h100, 64'h200, 64'h300, 64'h400, 32'h1234_0044,
                              0, 1, 0));
        // disabled guest slot equal to the disabled ignored entry
        send_context(make_ctx(OFF_ADDR, 64'h8, 64'h9, 64'ha,
                              32'h0000_0054 | (32'h3 << dbsm_pkg::CTL_COND_LSB),
                              1, 0, 1));
        // walking enable through each slot
        for (int i = 0; i < dbsm_pkg::SLOT_NUM; i++)
            send_context(make_ctx(BIT58, ALL_ONES, 64'h77, HIGH_ONLY | 64'h3,
                                  32'hfedc_0000 | (32'h1 << (2*i)), i[0], 1, 0));
    endtask

    function automatic dbsm_pkg::t_slot_set phase_setting(int p);
        dbsm_pkg::t_slot_set s;
        case (p)
            0: s = '0;
            1: s = '1;
            5: s = directed_setting();
            default: begin
                for (int i = 0; i < dbsm_pkg::SLOT_NUM; i++) begin
                    s.wanted[i] = rand_slot();
                    s.ignored[i] = rand_slot();
                end
            end
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        cur_set = '0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_guest_address_0 <= '0;
        i_guest_address_1 <= '0;
        i_guest_address_2 <= '0;
        i_guest_address_3 <= '0;
        i_guest_control <= '0;
        i_kernel_mode <= 1'b0;
        i_tracing_supported <= 1'b0;
        i_tracing_busy <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gap_pct = 30;
        ready_stall_pct = 30;
        load_setting(directed_setting());
        run_directed();
        wait_drain();

        for (int p = 0; p < PHASES; p++) begin
            load_setting(phase_setting(p));
            // phase 1 runs flat out on both sides
            send_gap_pct = (p == 1) ? 0 : 30;
            ready_stall_pct = (p == 1) ? 0 : 30;
            // phase 3 holds the result side off while items keep coming
            if (p == 3) begin
                send_gap_pct = 0;
                hold_req = 1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_context(rand_context());
            wait_drain();
        end

        if (sb.mismatch_count == 0)
            $display("PASS debug_breakpoint_slot_merger");
        else
            $display("FAIL debug_breakpoint_slot_merger");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL debug_breakpoint_slot_merger");
        $finish;
    end

endmodule
